// ===== design/mqttrx_pkg.sv =====
// Shared types, codes and constants of the MQTT receive engine.
package mqttrx_pkg;

  localparam logic [15:0] MAX_TOPIC   = 16'd127;
  localparam int          MAX_RESULTS = 5;
  localparam int          RESQ_DEPTH  = 8;
  localparam int          RESQ_AW     = $clog2(RESQ_DEPTH);

  localparam logic [3:0] T_CONNACK  = 4'd2;
  localparam logic [3:0] T_PUBLISH  = 4'd3;
  localparam logic [3:0] T_PUBACK   = 4'd4;
  localparam logic [3:0] T_PUBREC   = 4'd5;
  localparam logic [3:0] T_SUBACK   = 4'd9;
  localparam logic [3:0] T_UNSUBACK = 4'd11;
  localparam logic [3:0] T_PINGRESP = 4'd13;

  typedef enum logic {
    OP_RX  = 1'b0,
    OP_REQ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REQ_CONNECT    = 3'd0,
    REQ_DISCONNECT = 3'd1,
    REQ_PING       = 3'd2,
    REQ_PUBLISH    = 3'd3,
    REQ_SUBSCRIBE  = 3'd4,
    REQ_UNSUB      = 3'd5,
    REQ_NONE       = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    KIND_REQ_STATUS = 3'd0,
    KIND_RSP_STATUS = 3'd1,
    KIND_TOPIC      = 3'd2,
    KIND_PAYLOAD    = 3'd3,
    KIND_ACK_TX     = 3'd4,
    KIND_PUB_START  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_UNEXPECTED  = 4'd1,
    ST_BAD_SIZE    = 4'd2,
    ST_BAD_CONTENT = 4'd3,
    ST_OVERLONG    = 4'd4,
    ST_TOPIC_LONG  = 4'd5,
    ST_BAD_QOS     = 4'd6,
    ST_MALFORMED   = 4'd7,
    ST_REJECTED    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    PH_HDR     = 3'd0,
    PH_LEN     = 3'd1,
    PH_BODY    = 3'd2,
    PH_TLEN    = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_PID     = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_SKIP    = 3'd7
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [2:0] request_code;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [3:0]  status;
    logic [1:0]  qos_level_out;
    logic [27:0] pay_len;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [2:0]                   count;
    out_t [MAX_RESULTS-1:0]       item;
  } batch_t;

endpackage

// ===== design/mqtt_receive_protocol_engine.sv =====
// Top level of the MQTT client receive engine: input register, parser and result queue.
//
// Takes one beat per cycle (a received byte or a local request) into an input register;
// the parser handles it once the queue has room and writes its zero to five results into an
// eight-entry queue, which hands out one result per cycle while the receiver is ready. The
// first result of a beat passes through the input register and then the queue memory.
// Input is held back while the queue has fewer than five free entries, so a run of packet
// id bytes, each closing a QoS 1 or 2 publish header with five results, is paced by the
// one-per-cycle output drain.
module mqtt_receive_protocol_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mqttrx_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mqttrx_pkg::out_t out_data_o
);

  logic                          in_valid_q, in_valid_d;
  mqttrx_pkg::in_t               in_q;
  logic                          proc_fire;
  mqttrx_pkg::batch_t            batch;
  logic [mqttrx_pkg::RESQ_AW:0]  level;

  assign proc_fire  = in_valid_q &&
                      (level <= (mqttrx_pkg::RESQ_AW+1)'(mqttrx_pkg::RESQ_DEPTH -
                                                         mqttrx_pkg::MAX_RESULTS));
  assign in_ready_o = !in_valid_q || proc_fire;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  mqttrx_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (proc_fire),
    .item_i  (in_q),
    .batch_o (batch)
  );

  mqttrx_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (proc_fire),
    .batch_i (batch),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o),
    .level_o (level)
  );

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= (mqttrx_pkg::RESQ_AW+1)'(mqttrx_pkg::RESQ_DEPTH))
    else $error("result queue overflow");

  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |-> batch.count <= 3'(mqttrx_pkg::MAX_RESULTS))
    else $error("batch larger than queue headroom");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_q)))
    else $error("stalled beat lost from input register");

  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level == '0) |-> !out_valid_o)
    else $error("output valid with empty queue");

endmodule

// ===== design/mqttrx_parser.sv =====
// Packet parser and connection tracker: turns one beat into a batch of results.
module mqttrx_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mqttrx_pkg::in_t    item_i,
  output mqttrx_pkg::batch_t batch_o
);

  logic                 conn_q, conn_d;
  logic [2:0]           pend_q, pend_d;
  mqttrx_pkg::phase_e   phase_q, phase_d;
  logic [3:0]           ptype_q, ptype_d;
  logic [3:0]           pflags_q, pflags_d;
  logic [27:0]          rem_q, rem_d;
  logic [2:0]           lbc_q, lbc_d;
  logic [1:0]           bidx_q, bidx_d;
  logic [7:0]           saved_q, saved_d;
  logic [15:0]          topic_q, topic_d;
  logic [1:0]           qos_q, qos_d;
  logic                 bad_q, bad_d;

  logic [7:0]           b;
  logic [27:0]          rem_dec;
  logic [27:0]          len_part;
  logic [27:0]          acc;
  logic [2:0]           lbc_inc;
  logic [2:0]           rsp_req;
  logic [1:0]           rsp_size;
  logic [7:0]           want;
  logic                 body_bad;
  logic [15:0]          topic_new;
  logic [15:0]          topic_dec;
  logic [1:0]           tl_qos;
  logic [27:0]          need;
  logic [1:0]           pub_qos;
  mqttrx_pkg::out_t     pstart;
  mqttrx_pkg::phase_e   pstart_phase;
  mqttrx_pkg::phase_e   skip_acc;
  mqttrx_pkg::phase_e   skip_dec;

  function automatic mqttrx_pkg::out_t mk(
    input logic [2:0]  kind,
    input logic [7:0]  bv,
    input logic [3:0]  st,
    input logic [1:0]  q,
    input logic [27:0] plen,
    input logic        lst
  );
    mqttrx_pkg::out_t r;
    r.kind           = kind;
    r.byte_value     = bv;
    r.status         = st;
    r.qos_level_out  = q;
    r.pay_len        = plen;
    r.last           = lst;
    return r;
  endfunction

  function automatic mqttrx_pkg::out_t stat(input logic [2:0] kind, input logic [3:0] st);
    return mk(kind, 8'd0, st, 2'd0, 28'd0, 1'b0);
  endfunction

  assign b         = item_i.rx_byte;
  assign rem_dec   = rem_q - 28'd1;
  assign acc       = rem_q | len_part;
  assign lbc_inc   = lbc_q + 3'd1;
  assign topic_new = {saved_q, b};
  assign topic_dec = topic_q - 16'd1;
  assign tl_qos    = pflags_q[2:1];
  assign need      = {12'd0, topic_new} + ((tl_qos != 2'd0) ? 28'd2 : 28'd0);
  assign pub_qos   = (phase_q == mqttrx_pkg::PH_TLEN) ? tl_qos : qos_q;
  assign pstart    = mk(mqttrx_pkg::KIND_PUB_START, 8'd0, mqttrx_pkg::ST_OK, pub_qos,
                        rem_dec, 1'b0);
  assign pstart_phase = (rem_dec == 28'd0) ? mqttrx_pkg::PH_HDR : mqttrx_pkg::PH_PAYLOAD;
  assign skip_acc  = (acc == 28'd0) ? mqttrx_pkg::PH_HDR : mqttrx_pkg::PH_SKIP;
  assign skip_dec  = (rem_dec == 28'd0) ? mqttrx_pkg::PH_HDR : mqttrx_pkg::PH_SKIP;

  always_comb begin
    case (lbc_q[1:0])
      2'd0:    len_part = {21'd0, b[6:0]};
      2'd1:    len_part = {14'd0, b[6:0], 7'd0};
      2'd2:    len_part = {7'd0, b[6:0], 14'd0};
      default: len_part = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    unique case (ptype_q)
      mqttrx_pkg::T_CONNACK:  begin rsp_req = mqttrx_pkg::REQ_CONNECT;   rsp_size = 2'd2; end
      mqttrx_pkg::T_PUBACK:   begin rsp_req = mqttrx_pkg::REQ_PUBLISH;   rsp_size = 2'd2; end
      mqttrx_pkg::T_SUBACK:   begin rsp_req = mqttrx_pkg::REQ_SUBSCRIBE; rsp_size = 2'd3; end
      mqttrx_pkg::T_UNSUBACK: begin rsp_req = mqttrx_pkg::REQ_UNSUB;     rsp_size = 2'd2; end
      mqttrx_pkg::T_PINGRESP: begin rsp_req = mqttrx_pkg::REQ_PING;      rsp_size = 2'd0; end
      default:                begin rsp_req = mqttrx_pkg::REQ_NONE;      rsp_size = 2'd0; end
    endcase
  end

  always_comb begin
    want = 8'd0;
    if (bidx_q == 2'd1) begin
      want = (ptype_q == mqttrx_pkg::T_UNSUBACK) ? 8'd2 : 8'd1;
    end
    body_bad = (bidx_q == 2'd2) ? (b > 8'd2) : (b != want);
  end

  always_comb begin
    conn_d   = conn_q;
    pend_d   = pend_q;
    phase_d  = phase_q;
    ptype_d  = ptype_q;
    pflags_d = pflags_q;
    rem_d    = rem_q;
    lbc_d    = lbc_q;
    bidx_d   = bidx_q;
    saved_d  = saved_q;
    topic_d  = topic_q;
    qos_d    = qos_q;
    bad_d    = bad_q;
    batch_o  = '0;
    if (step_i) begin
      if (item_i.op == mqttrx_pkg::OP_REQ) begin
        if (!conn_q) begin
          if (item_i.request_code == mqttrx_pkg::REQ_CONNECT) begin
            pend_d = mqttrx_pkg::REQ_CONNECT;
          end else begin
            batch_o.count   = 3'd1;
            batch_o.item[0] = stat(mqttrx_pkg::KIND_REQ_STATUS, mqttrx_pkg::ST_UNEXPECTED);
          end
        end else if (item_i.request_code == mqttrx_pkg::REQ_DISCONNECT) begin
          conn_d          = 1'b0;
          batch_o.count   = 3'd1;
          batch_o.item[0] = stat(mqttrx_pkg::KIND_REQ_STATUS, mqttrx_pkg::ST_OK);
        end else if (item_i.request_code >= mqttrx_pkg::REQ_PING &&
                     item_i.request_code <= mqttrx_pkg::REQ_UNSUB) begin
          pend_d = item_i.request_code;
        end else begin
          batch_o.count   = 3'd1;
          batch_o.item[0] = stat(mqttrx_pkg::KIND_REQ_STATUS, mqttrx_pkg::ST_UNEXPECTED);
        end
      end else begin
        unique case (phase_q)
          mqttrx_pkg::PH_HDR: begin
            ptype_d  = b[7:4];
            pflags_d = b[3:0];
            rem_d    = '0;
            lbc_d    = '0;
            phase_d  = mqttrx_pkg::PH_LEN;
          end
          mqttrx_pkg::PH_LEN: begin
            rem_d = acc;
            lbc_d = lbc_inc;
            if (b[7]) begin
              if (lbc_inc >= 3'd4) begin
                phase_d         = mqttrx_pkg::PH_HDR;
                batch_o.count   = 3'd1;
                batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS, mqttrx_pkg::ST_OVERLONG);
              end
            end else begin
              bidx_d = '0;
              bad_d  = 1'b0;
              if (rsp_req != mqttrx_pkg::REQ_NONE) begin
                if (pend_q != rsp_req) begin
                  phase_d         = skip_acc;
                  batch_o.count   = 3'd1;
                  batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                         mqttrx_pkg::ST_UNEXPECTED);
                end else begin
                  pend_d = mqttrx_pkg::REQ_NONE;
                  if (acc != {26'd0, rsp_size}) begin
                    phase_d         = skip_acc;
                    batch_o.count   = 3'd1;
                    batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                           mqttrx_pkg::ST_BAD_SIZE);
                  end else if (rsp_size == 2'd0) begin
                    phase_d         = mqttrx_pkg::PH_HDR;
                    batch_o.count   = 3'd1;
                    batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS, mqttrx_pkg::ST_OK);
                  end else begin
                    phase_d = mqttrx_pkg::PH_BODY;
                  end
                end
              end else if (ptype_q == mqttrx_pkg::T_PUBLISH) begin
                if (acc < 28'd2) begin
                  phase_d         = skip_acc;
                  batch_o.count   = 3'd1;
                  batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                         mqttrx_pkg::ST_MALFORMED);
                end else begin
                  phase_d = mqttrx_pkg::PH_TLEN;
                end
              end else begin
                phase_d = skip_acc;
              end
            end
          end
          mqttrx_pkg::PH_BODY: begin
            rem_d  = rem_dec;
            bidx_d = bidx_q + 2'd1;
            if (ptype_q == mqttrx_pkg::T_CONNACK) begin
              if (bidx_q == 2'd0) begin
                bad_d = (b != 8'd0);
              end else begin
                phase_d       = mqttrx_pkg::PH_HDR;
                batch_o.count = 3'd1;
                if (bad_q) begin
                  batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                         mqttrx_pkg::ST_BAD_CONTENT);
                end else if (b != 8'd0) begin
                  batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                         mqttrx_pkg::ST_REJECTED);
                end else begin
                  conn_d          = 1'b1;
                  batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS, mqttrx_pkg::ST_OK);
                end
              end
            end else begin
              bad_d = bad_q | body_bad;
              if (rem_dec == 28'd0) begin
                phase_d         = mqttrx_pkg::PH_HDR;
                batch_o.count   = 3'd1;
                batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                       (bad_q | body_bad) ? mqttrx_pkg::ST_BAD_CONTENT
                                                          : mqttrx_pkg::ST_OK);
              end
            end
          end
          mqttrx_pkg::PH_TLEN: begin
            rem_d = rem_dec;
            if (bidx_q == 2'd0) begin
              saved_d = b;
              bidx_d  = 2'd1;
            end else begin
              topic_d = topic_new;
              qos_d   = tl_qos;
              if (topic_new > mqttrx_pkg::MAX_TOPIC) begin
                phase_d         = skip_dec;
                batch_o.count   = 3'd1;
                batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                       mqttrx_pkg::ST_TOPIC_LONG);
              end else if (tl_qos == 2'd3) begin
                phase_d         = skip_dec;
                batch_o.count   = 3'd1;
                batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS, mqttrx_pkg::ST_BAD_QOS);
              end else if (need > rem_dec) begin
                phase_d         = skip_dec;
                batch_o.count   = 3'd1;
                batch_o.item[0] = stat(mqttrx_pkg::KIND_RSP_STATUS,
                                       mqttrx_pkg::ST_MALFORMED);
              end else if (topic_new == 16'd0) begin
                if (tl_qos != 2'd0) begin
                  phase_d = mqttrx_pkg::PH_PID;
                  bidx_d  = '0;
                end else begin
                  phase_d         = pstart_phase;
                  batch_o.count   = 3'd1;
                  batch_o.item[0] = pstart;
                end
              end else begin
                phase_d = mqttrx_pkg::PH_TOPIC;
              end
            end
          end
          mqttrx_pkg::PH_TOPIC: begin
            rem_d           = rem_dec;
            topic_d         = topic_dec;
            batch_o.count   = 3'd1;
            batch_o.item[0] = mk(mqttrx_pkg::KIND_TOPIC, b, mqttrx_pkg::ST_OK, 2'd0, 28'd0,
                                 topic_dec == 16'd0);
            if (topic_dec == 16'd0) begin
              if (qos_q != 2'd0) begin
                phase_d = mqttrx_pkg::PH_PID;
                bidx_d  = '0;
              end else begin
                phase_d         = pstart_phase;
                batch_o.count   = 3'd2;
                batch_o.item[1] = pstart;
              end
            end
          end
          mqttrx_pkg::PH_PID: begin
            rem_d = rem_dec;
            if (bidx_q == 2'd0) begin
              saved_d = b;
              bidx_d  = 2'd1;
            end else begin
              phase_d         = pstart_phase;
              batch_o.count   = 3'd5;
              batch_o.item[0] = mk(mqttrx_pkg::KIND_ACK_TX,
                                   {(qos_q == 2'd1) ? mqttrx_pkg::T_PUBACK
                                                    : mqttrx_pkg::T_PUBREC, 4'd0},
                                   mqttrx_pkg::ST_OK, 2'd0, 28'd0, 1'b0);
              batch_o.item[1] = mk(mqttrx_pkg::KIND_ACK_TX, 8'd2, mqttrx_pkg::ST_OK, 2'd0,
                                   28'd0, 1'b0);
              batch_o.item[2] = mk(mqttrx_pkg::KIND_ACK_TX, saved_q, mqttrx_pkg::ST_OK, 2'd0,
                                   28'd0, 1'b0);
              batch_o.item[3] = mk(mqttrx_pkg::KIND_ACK_TX, b, mqttrx_pkg::ST_OK, 2'd0,
                                   28'd0, 1'b1);
              batch_o.item[4] = pstart;
            end
          end
          mqttrx_pkg::PH_PAYLOAD: begin
            rem_d           = rem_dec;
            batch_o.count   = 3'd1;
            batch_o.item[0] = mk(mqttrx_pkg::KIND_PAYLOAD, b, mqttrx_pkg::ST_OK, 2'd0, 28'd0,
                                 rem_dec == 28'd0);
            if (rem_dec == 28'd0) begin
              phase_d = mqttrx_pkg::PH_HDR;
            end
          end
          default: begin
            rem_d = rem_dec;
            if (rem_dec == 28'd0) begin
              phase_d = mqttrx_pkg::PH_HDR;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q   <= 1'b0;
      pend_q   <= mqttrx_pkg::REQ_NONE;
      phase_q  <= mqttrx_pkg::PH_HDR;
      ptype_q  <= '0;
      pflags_q <= '0;
      rem_q    <= '0;
      lbc_q    <= '0;
      bidx_q   <= '0;
      saved_q  <= '0;
      topic_q  <= '0;
      qos_q    <= '0;
      bad_q    <= 1'b0;
    end else begin
      conn_q   <= conn_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      ptype_q  <= ptype_d;
      pflags_q <= pflags_d;
      rem_q    <= rem_d;
      lbc_q    <= lbc_d;
      bidx_q   <= bidx_d;
      saved_q  <= saved_d;
      topic_q  <= topic_d;
      qos_q    <= qos_d;
      bad_q    <= bad_d;
    end
  end

endmodule

// ===== design/mqttrx_resq.sv =====
// Result queue: takes a batch of up to five results at once, hands out one per beat.
module mqttrx_resq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_i,
  input  mqttrx_pkg::batch_t              batch_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output mqttrx_pkg::out_t                data_o,
  output logic [mqttrx_pkg::RESQ_AW:0]    level_o
);

  mqttrx_pkg::out_t                 mem_q [mqttrx_pkg::RESQ_DEPTH];
  logic [mqttrx_pkg::RESQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mqttrx_pkg::RESQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mqttrx_pkg::RESQ_AW:0]     level_q, level_d;
  logic [mqttrx_pkg::RESQ_AW:0]     wr_cnt;
  logic                             pop;

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;
  assign pop     = valid_o && ready_i;
  assign wr_cnt  = wr_i ? (mqttrx_pkg::RESQ_AW+1)'(batch_i.count) : '0;

  always_comb begin
    wr_ptr_d = wr_ptr_q + mqttrx_pkg::RESQ_AW'(wr_cnt);
    rd_ptr_d = rd_ptr_q + (pop ? mqttrx_pkg::RESQ_AW'(1) : '0);
    level_d  = level_q + wr_cnt - (pop ? (mqttrx_pkg::RESQ_AW+1)'(1) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      for (int k = 0; k < mqttrx_pkg::MAX_RESULTS; k++) begin
        if (3'(k) < batch_i.count) begin
          mem_q[wr_ptr_q + mqttrx_pkg::RESQ_AW'(k)] <= batch_i.item[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

// ===== verif/mqtt_receive_protocol_engine_checker.sv =====
// Watches both channels of the MQTT receive engine, predicts every result and compares it.
`timescale 1ns / 1ps
module mqtt_receive_protocol_engine_checker
  import mqttrx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   beats_seen_o,
  output int   reports_due_o,
  output int   fail_count_o
);

  logic        connected;
  req_e        awaiting;
  phase_e      phase;
  logic [3:0]  ptype;
  logic [3:0]  pflags;
  logic [27:0] remaining;
  logic [2:0]  len_bytes;
  logic [1:0]  body_idx;
  logic [7:0]  high_byte;
  logic [15:0] topic_left;
  logic [1:0]  qos;
  logic        broken;

  out_t reports_q[$];
  int   beats_seen = 0;
  int   fail_count = 0;

  function automatic void add_report(kind_e k, logic [7:0] b, status_e s, logic [1:0] q,
                                     logic [27:0] plen, logic l);
    out_t r;
    r.kind           = k;
    r.byte_value     = b;
    r.status         = s;
    r.qos_level_out  = q;
    r.pay_len        = plen;
    r.last           = l;
    reports_q.push_back(r);
  endfunction

  function automatic void respond(status_e s);
    add_report(KIND_RSP_STATUS, 8'h00, s, 2'd0, 28'd0, 1'b0);
  endfunction

  function automatic void request_status(status_e s);
    add_report(KIND_REQ_STATUS, 8'h00, s, 2'd0, 28'd0, 1'b0);
  endfunction

  function automatic void skip_rest();
    if (remaining == 28'd0) begin
      phase = PH_HDR;
    end else begin
      phase = PH_SKIP;
    end
  endfunction

  function automatic void publish_start();
    add_report(KIND_PUB_START, 8'h00, ST_OK, qos, remaining, 1'b0);
    if (remaining == 28'd0) begin
      phase = PH_HDR;
    end else begin
      phase = PH_PAYLOAD;
    end
  endfunction

  function automatic void topic_done();
    if (qos != 2'd0) begin
      phase    = PH_PID;
      body_idx = 2'd0;
    end else begin
      publish_start();
    end
  endfunction

  function automatic void predict_reports(in_t beat);
    req_e       wanted;
    int         size;
    logic [1:0] idx;
    logic [7:0] want;
    logic [7:0] b;
    b = beat.rx_byte;
    if (beat.op == OP_REQ) begin
      if (!connected) begin
        if (beat.request_code == REQ_CONNECT) begin
          awaiting = REQ_CONNECT;
        end else begin
          request_status(ST_UNEXPECTED);
        end
      end else if (beat.request_code == REQ_DISCONNECT) begin
        connected = 1'b0;
        request_status(ST_OK);
      end else if (beat.request_code >= REQ_PING && beat.request_code <= REQ_UNSUB) begin
        awaiting = req_e'(beat.request_code);
      end else begin
        request_status(ST_UNEXPECTED);
      end
    end else begin
      case (phase)
        PH_HDR: begin
          ptype     = b[7:4];
          pflags    = b[3:0];
          remaining = 28'd0;
          len_bytes = 3'd0;
          phase     = PH_LEN;
        end
        PH_LEN: begin
          remaining = remaining | (28'(b[6:0]) << (7 * len_bytes[1:0]));
          len_bytes = len_bytes + 3'd1;
          if (b[7]) begin
            if (len_bytes >= 3'd4) begin
              phase = PH_HDR;
              respond(ST_OVERLONG);
            end
          end else begin
            body_idx = 2'd0;
            broken   = 1'b0;
            case (ptype)
              T_CONNACK: begin
                wanted = REQ_CONNECT;
                size   = 2;
              end
              T_PUBACK: begin
                wanted = REQ_PUBLISH;
                size   = 2;
              end
              T_SUBACK: begin
                wanted = REQ_SUBSCRIBE;
                size   = 3;
              end
              T_UNSUBACK: begin
                wanted = REQ_UNSUB;
                size   = 2;
              end
              T_PINGRESP: begin
                wanted = REQ_PING;
                size   = 0;
              end
              default: begin
                wanted = REQ_NONE;
                size   = 0;
              end
            endcase
            if (wanted != REQ_NONE) begin
              if (awaiting != wanted) begin
                skip_rest();
                respond(ST_UNEXPECTED);
              end else begin
                awaiting = REQ_NONE;
                if (int'(remaining) != size) begin
                  skip_rest();
                  respond(ST_BAD_SIZE);
                end else if (size == 0) begin
                  phase = PH_HDR;
                  respond(ST_OK);
                end else begin
                  phase = PH_BODY;
                end
              end
            end else if (ptype == T_PUBLISH) begin
              if (remaining < 28'd2) begin
                skip_rest();
                respond(ST_MALFORMED);
              end else begin
                phase = PH_TLEN;
              end
            end else begin
              skip_rest();
            end
          end
        end
        PH_BODY: begin
          idx       = body_idx;
          want      = 8'h00;
          remaining = remaining - 28'd1;
          body_idx  = idx + 2'd1;
          if (ptype == T_CONNACK) begin
            if (idx == 2'd0) begin
              broken = (b != 8'h00);
            end else begin
              phase = PH_HDR;
              if (broken) begin
                respond(ST_BAD_CONTENT);
              end else if (b != 8'h00) begin
                respond(ST_REJECTED);
              end else begin
                connected = 1'b1;
                respond(ST_OK);
              end
            end
          end else begin
            if (idx == 2'd1) begin
              want = (ptype == T_UNSUBACK) ? 8'h02 : 8'h01;
            end
            if (idx == 2'd2) begin
              if (b > 8'h02) broken = 1'b1;
            end else if (b != want) begin
              broken = 1'b1;
            end
            if (remaining == 28'd0) begin
              phase = PH_HDR;
              if (broken) begin
                respond(ST_BAD_CONTENT);
              end else begin
                respond(ST_OK);
              end
            end
          end
        end
        PH_TLEN: begin
          remaining = remaining - 28'd1;
          if (body_idx == 2'd0) begin
            high_byte = b;
            body_idx  = 2'd1;
          end else begin
            topic_left = {high_byte, b};
            qos        = pflags[2:1];
            if (topic_left > MAX_TOPIC) begin
              skip_rest();
              respond(ST_TOPIC_LONG);
            end else if (qos == 2'd3) begin
              skip_rest();
              respond(ST_BAD_QOS);
            end else if (int'(topic_left) + ((qos != 2'd0) ? 2 : 0) > int'(remaining)) begin
              skip_rest();
              respond(ST_MALFORMED);
            end else if (topic_left == 16'd0) begin
              topic_done();
            end else begin
              phase = PH_TOPIC;
            end
          end
        end
        PH_TOPIC: begin
          remaining  = remaining - 28'd1;
          topic_left = topic_left - 16'd1;
          add_report(KIND_TOPIC, b, ST_OK, 2'd0, 28'd0, topic_left == 16'd0);
          if (topic_left == 16'd0) topic_done();
        end
        PH_PID: begin
          remaining = remaining - 28'd1;
          if (body_idx == 2'd0) begin
            high_byte = b;
            body_idx  = 2'd1;
          end else begin
            add_report(KIND_ACK_TX, {(qos == 2'd1) ? T_PUBACK : T_PUBREC, 4'h0}, ST_OK, 2'd0,
                       28'd0, 1'b0);
            add_report(KIND_ACK_TX, 8'h02, ST_OK, 2'd0, 28'd0, 1'b0);
            add_report(KIND_ACK_TX, high_byte, ST_OK, 2'd0, 28'd0, 1'b0);
            add_report(KIND_ACK_TX, b, ST_OK, 2'd0, 28'd0, 1'b1);
            publish_start();
          end
        end
        PH_PAYLOAD: begin
          remaining = remaining - 28'd1;
          if (remaining == 28'd0) phase = PH_HDR;
          add_report(KIND_PAYLOAD, b, ST_OK, 2'd0, 28'd0, remaining == 28'd0);
        end
        default: begin
          remaining = remaining - 28'd1;
          if (remaining == 28'd0) phase = PH_HDR;
        end
      endcase
    end
  endfunction

  function automatic bit field_ok(string label, logic [27:0] want, logic [27:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : watch
    out_t want;
    bit   ok;
    if (!rst_ni) begin
      connected  = 1'b0;
      awaiting   = REQ_NONE;
      phase      = PH_HDR;
      ptype      = 4'd0;
      pflags     = 4'd0;
      remaining  = 28'd0;
      len_bytes  = 3'd0;
      body_idx   = 2'd0;
      high_byte  = 8'd0;
      topic_left = 16'd0;
      qos        = 2'd0;
      broken     = 1'b0;
      reports_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        beats_seen++;
        predict_reports(in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          $display("%0t: result with none expected, kind %0d byte %0h status %0d",
                   $time, out_data_i.kind, out_data_i.byte_value, out_data_i.status);
          fail_count++;
        end else begin
          want = reports_q.pop_front();
          ok = field_ok("kind", 28'(want.kind), 28'(out_data_i.kind))
             & field_ok("byte_value", 28'(want.byte_value), 28'(out_data_i.byte_value))
             & field_ok("status", 28'(want.status), 28'(out_data_i.status))
             & field_ok("qos_level_out", 28'(want.qos_level_out), 28'(out_data_i.qos_level_out))
             & field_ok("pay_len", want.pay_len, out_data_i.pay_len)
             & field_ok("last", 28'(want.last), 28'(out_data_i.last));
          if (!ok) fail_count++;
        end
      end
    end
    beats_seen_o  <= beats_seen;
    reports_due_o <= reports_q.size();
    fail_count_o  <= fail_count;
  end

endmodule

// ===== verif/mqtt_receive_protocol_engine_tb.sv =====
// Stimulus and verdict for the MQTT receive engine: packet traffic, requests and back-pressure.
`timescale 1ns / 1ps
module mqtt_receive_protocol_engine_tb;
  import mqttrx_pkg::*;

  typedef logic [7:0] octets_t[$];

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         RANDOM_BEATS  = 90;
  localparam int         SETTLE_CYCLES = 20;
  localparam logic [2:0] REQ_UNDEFINED = 3'd7;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  int beats_seen;
  int reports_due;
  int fail_count;
  int beats_sent   = 0;
  int cycle_count  = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  mqtt_receive_protocol_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  mqtt_receive_protocol_engine_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .beats_seen_o  (beats_seen),
    .reports_due_o (reports_due),
    .fail_count_o  (fail_count)
  );

  always #5 clk_i = ~clk_i;

  task automatic put_beat(in_t beat);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    in_t beat;
    beat.op           = OP_RX;
    beat.rx_byte      = b;
    beat.request_code = 3'($urandom);
    put_beat(beat);
  endtask

  task automatic put_request(logic [2:0] code);
    in_t beat;
    beat.op           = OP_REQ;
    beat.rx_byte      = 8'($urandom);
    beat.request_code = code;
    put_beat(beat);
  endtask

  // Length goes out in its shortest form or padded with continuation bytes.
  task automatic put_packet(logic [7:0] hdr, octets_t body);
    int n;
    int k;
    n = body.size();
    k = 1;
    while ((n >> (7 * k)) != 0) k++;
    if ($urandom_range(3) == 0) k = $urandom_range(4, k);
    put_byte(hdr);
    for (int i = 0; i < k; i++) begin
      put_byte(8'((n >> (7 * i)) & 'h7f) | ((i < k - 1) ? 8'h80 : 8'h00));
    end
    foreach (body[i]) put_byte(body[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (beats_seen != beats_sent || reports_due != 0) @(posedge clk_i);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 20);
      @(posedge clk_i);
    end
  end

  initial begin
    octets_t     body;
    int          pick;
    int          variant;
    int          qos;
    int          tlen;
    int          plen;
    int          start;
    logic [15:0] declared;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    put_request(REQ_PING);
    put_request(REQ_UNDEFINED);
    put_request(REQ_CONNECT);
    body = {8'h00, 8'h00};
    put_packet({T_CONNACK, 4'h0}, body);
    put_request(REQ_CONNECT);
    body = {};
    put_packet({T_PINGRESP, 4'hf}, body);
    put_request(REQ_PING);
    put_packet({T_PINGRESP, 4'h0}, body);
    put_byte({T_PUBLISH, 4'h0});
    repeat (4) put_byte(8'hff);
    put_request(REQ_DISCONNECT);

    // Stall the receiver while a QoS 2 publish streams in.
    hold_request = 1'b1;
    body = {8'h00, 8'h01, 8'hff, 8'h00, 8'hff};
    repeat (12) body.push_back(8'($urandom));
    put_packet({T_PUBLISH, 4'b0100}, body);
    wait_drained();

    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      calm = (beats_sent - start >= 40) && (beats_sent - start < 80);
      pick = $urandom_range(9);
      body = {};
      case (pick)
        0, 1: begin
          put_request(REQ_CONNECT);
          variant = $urandom_range(4);
          body = {8'h00, 8'h00};
          if (variant == 2) begin
            body[0] = 8'($urandom_range(255, 1));
          end else if (variant == 3) begin
            body[1] = 8'($urandom_range(255, 1));
          end else if (variant == 4) begin
            body.push_back(8'h00);
          end
          put_packet({T_CONNACK, 4'($urandom)}, body);
        end
        2: begin
          put_request(REQ_PING);
          if ($urandom_range(3) == 0) body.push_back(8'($urandom));
          put_packet({T_PINGRESP, 4'($urandom)}, body);
        end
        3: begin
          put_request(REQ_PUBLISH);
          body = {8'h00, 8'h01};
          if ($urandom_range(3) == 0) body[$urandom_range(1)] = 8'($urandom);
          put_packet({T_PUBACK, 4'($urandom)}, body);
        end
        4: begin
          put_request(REQ_SUBSCRIBE);
          body = {8'h00, 8'h01, 8'($urandom_range(3))};
          variant = $urandom_range(5);
          if (variant == 0) begin
            body[2] = 8'($urandom);
          end else if (variant == 1) begin
            body[$urandom_range(1)] = 8'($urandom);
          end else if (variant == 2) begin
            void'(body.pop_back());
          end
          put_packet({T_SUBACK, 4'($urandom)}, body);
        end
        5: begin
          put_request(REQ_UNSUB);
          body = {8'h00, 8'h02};
          variant = $urandom_range(4);
          if (variant == 0) begin
            body[$urandom_range(1)] = 8'($urandom);
          end else if (variant == 1) begin
            body.push_back(8'($urandom));
          end
          put_packet({T_UNSUBACK, 4'($urandom)}, body);
        end
        6, 7: begin
          qos     = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
          tlen    = $urandom_range(5);
          plen    = $urandom_range(6);
          variant = $urandom_range(9);
          declared = 16'(tlen);
          if (variant == 7) begin
            declared = 16'($urandom_range(65535, int'(MAX_TOPIC) + 1));
          end else if (variant == 8) begin
            declared = 16'(tlen + plen + 1);
          end
          body = {declared[15:8], declared[7:0]};
          repeat (tlen) body.push_back(8'($urandom));
          if (qos != 0) repeat (2) body.push_back(8'($urandom));
          repeat (plen) body.push_back(8'($urandom));
          if (variant == 9) begin
            body = {};
            if ($urandom_range(1) == 1) body.push_back(8'($urandom));
          end
          put_packet({T_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)}, body);
        end
        8: begin
          repeat ($urandom_range(3)) body.push_back(8'($urandom));
          put_packet(8'($urandom), body);
        end
        default: begin
          put_request(3'($urandom_range(7)));
        end
      endcase
    end
    calm = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mqttrx_pkg.sv
design/mqttrx_parser.sv
design/mqttrx_resq.sv
design/mqtt_receive_protocol_engine.sv
verif/mqtt_receive_protocol_engine_checker.sv
verif/mqtt_receive_protocol_engine_tb.sv
